/* src/bss_pkg.sv */
// ---------------------------------------------------------------------------
// bss_pkg - shared types and constants of the separator splitter
// Byte, result and text-form types, register map codes and the byte
// classification used to build the text form of a segment byte.
// ---------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

   localparam int SEP_BYTES_W = 64;
   localparam int LEN_W       = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   // register index sits in address bit 3 (registers are 8 bytes apart)
   localparam int   REG_IDX_BIT   = 3;
   localparam logic REG_SEP_BYTES = 1'b0;
   localparam logic REG_SEP_LEN   = 1'b1;

   typedef logic [7:0] bss_byte_type;

   localparam bss_byte_type CHAR_NEWLINE = 8'h0A;
   localparam bss_byte_type CHAR_TAB     = 8'h09;
   localparam bss_byte_type CHAR_SPACE   = 8'h20;
   localparam bss_byte_type PRINT_LO     = 8'h20;
   localparam bss_byte_type PRINT_HI     = 8'h7E;

   localparam logic [SEP_BYTES_W-1:0] SEP_BYTES_RESET =
      {{(SEP_BYTES_W-8){1'b0}}, CHAR_NEWLINE};
   localparam logic [LEN_W-1:0] SEP_LEN_RESET = 4'd1;

   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_RAW  = 1'b1;

   typedef struct packed {
      bss_byte_type raw_byte;
      bss_byte_type text_byte;
      logic         text_keep;
      logic         has_byte;
      logic         segment_end;
      logic         segment_kind;
      logic         last_result;
   } bss_result_type;

   typedef struct packed {
      logic           valid;
      bss_result_type result;
   } bss_push_type;

   typedef struct packed {
      bss_byte_type text_byte;
      logic         keep;
   } bss_text_type;

   function automatic bss_text_type bss_text_form(input bss_byte_type b);
      bss_text_type t;
      t = '0;
      if ((b >= PRINT_LO) && (b <= PRINT_HI)) begin
         t.text_byte = b;
         t.keep      = 1'b1;
      end else if (b == CHAR_TAB) begin
         t.text_byte = CHAR_SPACE;
         t.keep      = 1'b1;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

/* src/bss_req_if.sv */
// ---------------------------------------------------------------------------
// bss_req_if - input byte channel
// Valid/ready channel carrying one buffer byte and its flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface bss_req_if import bss_pkg::*; ();
   logic         valid;
   logic         ready;
   bss_byte_type data_byte;
   logic         has_data;
   logic         end_of_buffer;

   modport source (output valid, data_byte, has_data, end_of_buffer, input ready);
   modport sink   (input valid, data_byte, has_data, end_of_buffer, output ready);
endinterface

`default_nettype wire

/* src/bss_rsp_if.sv */
// ---------------------------------------------------------------------------
// bss_rsp_if - result channel
// Valid/ready channel carrying one segment byte or segment end.
// ---------------------------------------------------------------------------
`default_nettype none

interface bss_rsp_if import bss_pkg::*; ();
   logic         valid;
   logic         ready;
   bss_byte_type raw_byte;
   bss_byte_type text_byte;
   logic         text_keep;
   logic         has_byte;
   logic         segment_end;
   logic         segment_kind;
   logic         last_result;

   modport source (output valid, raw_byte, text_byte, text_keep, has_byte,
                   segment_end, segment_kind, last_result, input ready);
   modport sink   (input valid, raw_byte, text_byte, text_keep, has_byte,
                   segment_end, segment_kind, last_result, output ready);
endinterface

`default_nettype wire

/* src/bss_window.sv */
// ---------------------------------------------------------------------------
// bss_window - match window and result step
// Holds the undecided bytes and compares them with the separator; while
// push_ready is high it emits one result per cycle until an accepted transaction has no results left.
// ---------------------------------------------------------------------------
`default_nettype none

module bss_window import bss_pkg::*; #(
   parameter  int SEPARATOR_MAX = 8,
   localparam int CNT_W         = $clog2(SEPARATOR_MAX + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   bss_req_if.sink                req_chan,
   input  logic [SEP_BYTES_W-1:0] sep_bytes,
   input  logic [CNT_W-1:0]       sep_len,
   output bss_push_type           push,
   input  logic                   push_ready,
   output logic                   busy
);

   bss_byte_type   window_ff [SEPARATOR_MAX];
   bss_byte_type   window_in [SEPARATOR_MAX];
   bss_byte_type   win_shift [SEPARATOR_MAX];
   bss_byte_type   win_step  [SEPARATOR_MAX];
   logic [CNT_W-1:0] count_ff, count_in, count_after, count_step;
   logic [CNT_W-1:0] shift;
   logic             busy_ff, busy_in, eob_ff, eob_in;
   logic             match, drain, tail, more;
   logic             step_fire, take_item, accept, append;
   bss_result_type   res;
   bss_text_type     txt;

   // separator compare over the first sep_len window bytes
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < SEPARATOR_MAX; i++) begin
         if ((i < int'(sep_len)) && (window_ff[i] != sep_bytes[8*i +: 8]))
            match = 1'b0;
      end
   end

   // one result step
   always_comb begin
      drain = (count_ff >= sep_len);
      txt   = bss_text_form(window_ff[0]);
      res   = '0;
      shift = '0;
      tail  = 1'b0;
      if (drain && match) begin
         res.segment_end  = 1'b1;
         res.segment_kind = KIND_TEXT;
         shift            = sep_len;
      end else if (drain || (count_ff != '0)) begin
         res.has_byte  = 1'b1;
         res.raw_byte  = window_ff[0];
         res.text_byte = txt.text_byte;
         res.text_keep = txt.keep;
         shift         = CNT_W'(1);
      end else begin
         // flush done: remainder end
         res.segment_end  = 1'b1;
         res.segment_kind = KIND_RAW;
         tail             = 1'b1;
      end
      count_after     = count_ff - shift;
      more            = (count_after >= sep_len) || (eob_ff && !tail);
      res.last_result = !more;
   end

   always_comb begin
      for (int i = 0; i < SEPARATOR_MAX; i++) begin
         win_shift[i] = '0;
         for (int n = 1; n <= SEPARATOR_MAX; n++) begin
            if ((shift == CNT_W'(n)) && (i + n < SEPARATOR_MAX))
               win_shift[i] = window_ff[i + n];
         end
      end
   end

   assign step_fire = busy_ff && push_ready;
   assign take_item = !busy_ff || (step_fire && !more);
   assign accept    = req_chan.valid && take_item;

   always_comb begin
      count_step = step_fire ? count_after : count_ff;
      for (int i = 0; i < SEPARATOR_MAX; i++)
         win_step[i] = step_fire ? win_shift[i] : window_ff[i];
   end

   assign append = accept && req_chan.has_data && (count_step < CNT_W'(SEPARATOR_MAX));

   always_comb begin
      for (int i = 0; i < SEPARATOR_MAX; i++) begin
         window_in[i] = win_step[i];
         if (append && (count_step == CNT_W'(i)))
            window_in[i] = req_chan.data_byte;
      end
      count_in = count_step + CNT_W'(append);
      if (accept) begin
         busy_in = (req_chan.has_data || req_chan.end_of_buffer) &&
                   (req_chan.end_of_buffer || (count_in >= sep_len));
         eob_in  = req_chan.end_of_buffer;
      end else begin
         busy_in = step_fire ? more : busy_ff;
         eob_in  = eob_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SEPARATOR_MAX; i++)
            window_ff[i] <= '0;
         count_ff <= '0;
         busy_ff  <= 1'b0;
         eob_ff   <= 1'b0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
         busy_ff   <= busy_in;
         eob_ff    <= eob_in;
      end
   end

   assign req_chan.ready = take_item;
   assign push.valid     = step_fire;
   assign push.result    = res;
   assign busy           = busy_ff;

endmodule

`default_nettype wire

/* src/bss_out_skid.sv */
// ---------------------------------------------------------------------------
// bss_out_skid - result output register with skid stage
// Two-entry buffer that keeps the upstream ready free of rsp ready.
// ---------------------------------------------------------------------------
`default_nettype none

module bss_out_skid import bss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bss_push_type push,
   output logic         push_ready,
   bss_rsp_if.source    rsp_chan
);

   bss_result_type main_ff, main_in, skid_ff, skid_in;
   logic           main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic           pop, take;

   assign push_ready = !skid_valid_ff;
   assign take       = push.valid && push_ready;
   assign pop        = main_valid_ff && rsp_chan.ready;

   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!main_valid_ff || pop) begin
         main_valid_in = skid_valid_ff || take;
         main_in       = skid_valid_ff ? skid_ff : push.result;
         skid_valid_in = 1'b0;
      end else if (take) begin
         skid_in       = push.result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid        = main_valid_ff;
   assign rsp_chan.raw_byte     = main_ff.raw_byte;
   assign rsp_chan.text_byte    = main_ff.text_byte;
   assign rsp_chan.text_keep    = main_ff.text_keep;
   assign rsp_chan.has_byte     = main_ff.has_byte;
   assign rsp_chan.segment_end  = main_ff.segment_end;
   assign rsp_chan.segment_kind = main_ff.segment_kind;
   assign rsp_chan.last_result  = main_ff.last_result;

endmodule

`default_nettype wire

/* src/byte_stream_separator_splitter_top.sv */
// ---------------------------------------------------------------------------
// byte_stream_separator_splitter_top - byte stream splitter on a separator
// Splits a byte stream at a configured separator of 1 to SEPARATOR_MAX bytes
// and reports each segment byte raw and in text form.
//
// Channels: req_chan takes one byte transaction (data_byte, has_data,
// end_of_buffer); rsp_chan gives one result transaction per segment byte or
// segment end, last_result marking the final result of an input transaction.
// Separator bytes and length sit in two 64-bit APB registers at 0x0 and 0x8,
// to be written only while the block is idle; the block does not enforce it.
// Timing: a transaction taken on req_chan sets the step busy register, and
// its first result then passes the output register before it is valid on
// rsp_chan. Throughput: a transaction takes one window step per result, one
// step per cycle while the output buffer has room; one that gives none does
// not occupy the step. The usual byte-in, byte-out stream runs at one
// transaction per cycle while rsp_chan keeps up; an end-of-buffer flush steps
// out the remaining window bytes and ends with a raw remainder end.
// Reset: window empty, separator a single newline, output buffer empty.
// Stall: a two-entry output buffer holds results while rsp_chan.ready is low;
// once both are full the step halts and, if busy, req_chan.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_stream_separator_splitter_top import bss_pkg::*; #(
   parameter  int SEPARATOR_MAX = 8,
   localparam int CNT_W         = $clog2(SEPARATOR_MAX + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   bss_req_if.sink               req_chan,
   bss_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [SEP_BYTES_W-1:0] sep_bytes_ff, sep_bytes_in;
   logic [LEN_W-1:0]       sep_len_ff, sep_len_in;
   logic [LEN_W-1:0]       len_clamp;
   logic                   csr_write;
   bss_push_type           push;
   logic                   push_ready;
   logic                   win_busy;

   // --- register port: decode on the index bit only ---
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      sep_bytes_in = sep_bytes_ff;
      sep_len_in   = sep_len_ff;
      if (csr_write) begin
         if (csr_paddr[REG_IDX_BIT] == REG_SEP_BYTES)
            sep_bytes_in = csr_pwdata[SEP_BYTES_W-1:0];
         else
            sep_len_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_bytes_ff <= SEP_BYTES_RESET;
         sep_len_ff   <= SEP_LEN_RESET;
      end else begin
         sep_bytes_ff <= sep_bytes_in;
         sep_len_ff   <= sep_len_in;
      end
   end

   assign csr_prdata = (csr_paddr[REG_IDX_BIT] == REG_SEP_LEN) ?
                       {{(CSR_DATA_W-LEN_W){1'b0}}, sep_len_ff} :
                       CSR_DATA_W'(sep_bytes_ff);

   // zero length acts as one, anything above the window depth as the depth
   always_comb begin
      if (sep_len_ff == '0)
         len_clamp = LEN_W'(1);
      else if (sep_len_ff > LEN_W'(SEPARATOR_MAX))
         len_clamp = LEN_W'(SEPARATOR_MAX);
      else
         len_clamp = sep_len_ff;
   end

   // --- window and result step ---
   bss_window #(
      .SEPARATOR_MAX (SEPARATOR_MAX)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .sep_bytes  (sep_bytes_ff),
      .sep_len    (len_clamp[CNT_W-1:0]),
      .push       (push),
      .push_ready (push_ready),
      .busy       (win_busy)
   );

   // --- output register and skid stage ---
   bss_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .rsp_chan   (rsp_chan)
   );

   // --- checks ---
   // a transaction in work with a full output buffer blocks new input
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (win_busy && !push_ready) |-> !req_chan.ready)
      else $error("input taken while result step stalled");

   // after the last result of a transaction the step goes idle unless a new one came in
   a_last_ends_work: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.result.last_result && !(req_chan.valid && req_chan.ready))
      |=> !win_busy)
      else $error("step still busy after last result");

   // results are only produced for a transaction in work
   a_push_needs_work: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (win_busy && push_ready))
      else $error("result pushed with no transaction in work");

endmodule

`default_nettype wire
